/* rtl/bmsirq_pkg.sv */
`default_nettype none

package bmsirq_pkg;

  // Default sizes handed to the top level.
  localparam int WORK_RAM_DEPTH_DEF = 8192;
  localparam int A12_MIN_GAP_DEF    = 16;

  // Fixed field widths.
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int CYCLE_W  = 48;
  localparam int MAP_W    = 22;
  localparam int PRG_BANK_W = 9;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // Item modes.
  typedef enum logic [2:0] {
    MODE_CPU_READ  = 3'd0,
    MODE_CPU_WRITE = 3'd1,
    MODE_PPU_READ  = 3'd2,
    MODE_PPU_WRITE = 3'd3,
    MODE_SYNC      = 3'd4
  } mode_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_RAM  = 2'd1,
    KIND_PRG  = 2'd2,
    KIND_CHR  = 2'd3
  } kind_t;

  // Mapper register decode: {address[14:13], address[0]}.
  typedef enum logic [2:0] {
    REG_BANK_SELECT = 3'd0,
    REG_BANK_DATA   = 3'd1,
    REG_MIRROR      = 3'd2,
    REG_RAM_PROTECT = 3'd3,
    REG_IRQ_LATCH   = 3'd4,
    REG_IRQ_RELOAD  = 3'd5,
    REG_IRQ_DISABLE = 3'd6,
    REG_IRQ_ENABLE  = 3'd7
  } reg_code_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PRG_ROM_BANKS = 2'd0,
    CFG_CHR_IS_RAM    = 2'd1,
    CFG_QUAD_SCREEN   = 2'd2
  } cfg_index_t;

  // Mirroring codes.
  localparam logic [1:0] MIRROR_QUAD_SCREEN = 2'd2;

  // Bank state seen by the address translator.
  typedef struct packed {
    logic [7:0]      prg_rom_banks;
    logic [7:0]      bank_select;
    logic [7:0][7:0] regs;
  } bank_state_t;

endpackage

`default_nettype wire

/* rtl/bmsirq_ram.sv */
`default_nettype none

module bmsirq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/bmsirq_map.sv */
`default_nettype none

module bmsirq_map (
  input  wire bmsirq_pkg::bank_state_t            banks,
  input  wire logic [bmsirq_pkg::ADDR_W-1:0]      address,
  output logic      [bmsirq_pkg::MAP_W-1:0]       prg_address,
  output logic      [bmsirq_pkg::MAP_W-1:0]       chr_address
);

  logic [bmsirq_pkg::PRG_BANK_W-1:0] last_bank;
  logic [bmsirq_pkg::PRG_BANK_W-1:0] second_bank;
  logic [bmsirq_pkg::PRG_BANK_W-1:0] prg_bank;
  logic                              prg_swap;
  logic [12:0]                       chr_a;
  logic [7:0]                        chr_reg;
  logic [2:0]                        chr_sel;

  // The two fixed banks are the last two 8 KB banks, wrapping in nine bits.
  assign last_bank   = {1'b0, banks.prg_rom_banks} + {1'b0, banks.prg_rom_banks} - 9'd1;
  assign second_bank = {1'b0, banks.prg_rom_banks} + {1'b0, banks.prg_rom_banks} - 9'd2;
  assign prg_swap    = banks.bank_select[6];

  always_comb begin
    case (address[14:13])
      2'd0:    prg_bank = prg_swap ? second_bank : {1'b0, banks.regs[6]};
      2'd1:    prg_bank = {1'b0, banks.regs[7]};
      2'd2:    prg_bank = prg_swap ? {1'b0, banks.regs[6]} : second_bank;
      default: prg_bank = last_bank;
    endcase
    prg_address = {prg_bank, address[12:0]};
  end

  // CHR inversion swaps the 2 KB half and the 1 KB half of pattern space.
  always_comb begin
    chr_a   = {address[12] ^ banks.bank_select[7], address[11:0]};
    chr_sel = {1'b0, chr_a[11:10]} + 3'd2;
    if (!chr_a[12]) begin
      chr_reg     = chr_a[11] ? banks.regs[1] : banks.regs[0];
      chr_address = {4'd0, chr_reg[7:1], chr_a[10:0]};
    end else begin
      chr_reg     = banks.regs[chr_sel];
      chr_address = {4'd0, chr_reg, chr_a[9:0]};
    end
  end

endmodule

`default_nettype wire

/* rtl/bank_mapper_with_scanline_irq.sv */
// A result goes through stage one and then the output register on its way to the output.
// Throughput: one item per cycle while the input is not stalled; the work RAM takes one read
// and one write each cycle. Reset: synchronous and active high. Registers return to their
// power-on values, then a clearing pass writes zeros to all WORK_RAM_DEPTH bytes of the
// work RAM (8192 by default), one byte per cycle; no item is taken during the pass.
`default_nettype none

module bank_mapper_with_scanline_irq #(
  parameter int WORK_RAM_DEPTH = bmsirq_pkg::WORK_RAM_DEPTH_DEF,
  parameter int A12_MIN_GAP    = bmsirq_pkg::A12_MIN_GAP_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Configuration write port.
  input  wire logic                                cfg_write_enable,
  input  wire logic [bmsirq_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [bmsirq_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input item channel.
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [2:0]                          mode,
  input  wire logic [bmsirq_pkg::ADDR_W-1:0]       address,
  input  wire logic [bmsirq_pkg::DATA_W-1:0]       write_data,
  input  wire logic                                a12_level,
  input  wire logic [bmsirq_pkg::CYCLE_W-1:0]      ppu_cycle,
  // Result item channel.
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               kind,
  output logic [bmsirq_pkg::DATA_W-1:0]            ram_data,
  output logic [bmsirq_pkg::MAP_W-1:0]             mapped_address,
  output logic                                     chr_write_enable,
  output logic [1:0]                               mirroring,
  output logic                                     irq_line
);

  localparam int RAM_AW = $clog2(WORK_RAM_DEPTH);

  // Configuration registers.
  logic [7:0] prg_rom_banks;
  logic       chr_is_ram;
  logic       quad_screen;

  // Mapper state.
  logic [7:0]                         bank_select;
  logic [7:0]                         bank_select_next;
  logic [7:0][7:0]                    bank_regs;
  logic [7:0][7:0]                    bank_regs_next;
  logic                               mirror_horizontal;
  logic                               mirror_horizontal_next;
  logic [7:0]                         reload_period;
  logic [7:0]                         reload_period_next;
  logic [7:0]                         line_counter;
  logic [7:0]                         line_counter_next;
  logic                               irq_enable;
  logic                               irq_enable_next;
  logic                               irq_pending;
  logic                               irq_pending_next;
  logic [bmsirq_pkg::CYCLE_W-1:0]     last_a12_cycle;
  logic [bmsirq_pkg::CYCLE_W-1:0]     last_a12_cycle_next;

  // Work RAM clearing pass.
  logic              clearing;
  logic [RAM_AW-1:0] clear_addr;

  // Handshake and pipeline control.
  logic in_accept;
  logic s1_valid;
  logic s1_advance;

  // Stage one holds everything but the RAM byte, which sits in the RAM's read register.
  bmsirq_pkg::kind_t              s1_kind;
  logic [bmsirq_pkg::MAP_W-1:0]   s1_address;
  logic                           s1_we;
  logic [1:0]                     s1_mirroring;
  logic                           s1_irq;

  // Output register.
  bmsirq_pkg::kind_t              out_kind;

  // Step logic.
  bmsirq_pkg::kind_t              step_kind;
  logic [bmsirq_pkg::MAP_W-1:0]   step_address;
  logic                           step_we;
  bmsirq_pkg::reg_code_t          reg_code;
  logic [bmsirq_pkg::CYCLE_W-1:0] a12_gap;
  logic [7:0]                     counter_clocked;
  logic [15:0]                    ram_rem;
  logic [RAM_AW-1:0]              ram_index;
  logic                           ram_item_write;
  logic                           ram_we;
  logic [RAM_AW-1:0]              ram_waddr;
  logic [7:0]                     ram_wdata;
  logic [7:0]                     ram_rdata;

  bmsirq_pkg::bank_state_t        banks;
  logic [bmsirq_pkg::MAP_W-1:0]   prg_address;
  logic [bmsirq_pkg::MAP_W-1:0]   chr_address;

  // Outside the clearing pass, an item enters whenever stage one is empty or moves on in the same cycle.
  // A waiting result in the output register does not block the input as long
  // as stage one still has room.
  assign in_stall   = clearing || (s1_valid && out_valid && out_stall);
  assign in_accept  = in_valid && !in_stall;
  assign s1_advance = s1_valid && (!out_valid || !out_stall);

  // The mapper register class comes from address bits 14, 13 and 0.
  assign reg_code = bmsirq_pkg::reg_code_t'({address[14:13], address[0]});

  // Work RAM index is the low 13 bits folded into the RAM depth. Three conditional
  // subtractions finish the job as long as the quotient is at most seven.
  always_comb begin
    ram_rem = {3'd0, address[12:0]};
    for (int k = 2; k >= 0; k--) begin
      if (ram_rem >= 16'(WORK_RAM_DEPTH << k)) begin
        ram_rem = ram_rem - 16'(WORK_RAM_DEPTH << k);
      end
    end
    ram_index = ram_rem[RAM_AW-1:0];
  end

  // Address translation through the PRG and CHR windows.
  assign banks.prg_rom_banks = prg_rom_banks;
  assign banks.bank_select   = bank_select;
  assign banks.regs          = bank_regs;

  bmsirq_map u_map (
    .banks       (banks),
    .address     (address),
    .prg_address (prg_address),
    .chr_address (chr_address)
  );

  // Scanline counter: a sync item with A12 high, far enough from the previous
  // A12-high sample, clocks the counter. Zero reloads, anything else counts down.
  assign a12_gap         = ppu_cycle - last_a12_cycle;
  assign counter_clocked = (line_counter == 8'd0) ? reload_period : line_counter - 8'd1;

  // Next state of the mapper registers. Nothing moves unless an item is accepted.
  always_comb begin
    bank_select_next       = bank_select;
    bank_regs_next         = bank_regs;
    mirror_horizontal_next = mirror_horizontal;
    reload_period_next     = reload_period;
    line_counter_next      = line_counter;
    irq_enable_next        = irq_enable;
    irq_pending_next       = irq_pending;
    last_a12_cycle_next    = last_a12_cycle;
    ram_item_write         = 1'b0;

    if (in_accept) begin
      unique case (mode)
        bmsirq_pkg::MODE_CPU_WRITE: begin
          if (!address[15]) begin
            ram_item_write = 1'b1;
          end else begin
            unique case (reg_code)
              bmsirq_pkg::REG_BANK_SELECT: bank_select_next = write_data;
              bmsirq_pkg::REG_BANK_DATA:   bank_regs_next[bank_select[2:0]] = write_data;
              bmsirq_pkg::REG_MIRROR:      mirror_horizontal_next = write_data[0];
              bmsirq_pkg::REG_IRQ_LATCH:   reload_period_next = write_data;
              bmsirq_pkg::REG_IRQ_RELOAD:  line_counter_next = 8'd0;
              bmsirq_pkg::REG_IRQ_DISABLE: begin
                irq_enable_next  = 1'b0;
                irq_pending_next = 1'b0;
              end
              bmsirq_pkg::REG_IRQ_ENABLE:  irq_enable_next = 1'b1;
              default: ;  // RAM protect is not modeled.
            endcase
          end
        end
        bmsirq_pkg::MODE_SYNC: begin
          if (a12_level) begin
            if (a12_gap > bmsirq_pkg::CYCLE_W'(A12_MIN_GAP)) begin
              line_counter_next = counter_clocked;
              if (counter_clocked == 8'd0 && irq_enable) begin
                irq_pending_next = 1'b1;
              end
            end
            last_a12_cycle_next = ppu_cycle;
          end
        end
        default: ;
      endcase
    end
  end

  // Result fields of the accepted item, apart from the RAM byte.
  always_comb begin
    step_kind    = bmsirq_pkg::KIND_NONE;
    step_address = '0;
    step_we      = 1'b0;
    unique case (mode)
      bmsirq_pkg::MODE_CPU_READ: begin
        if (!address[15]) begin
          step_kind = bmsirq_pkg::KIND_RAM;
        end else begin
          step_kind    = bmsirq_pkg::KIND_PRG;
          step_address = prg_address;
        end
      end
      bmsirq_pkg::MODE_PPU_READ: begin
        step_kind    = bmsirq_pkg::KIND_CHR;
        step_address = chr_address;
      end
      bmsirq_pkg::MODE_PPU_WRITE: begin
        step_kind    = bmsirq_pkg::KIND_CHR;
        step_address = chr_address;
        step_we      = chr_is_ram;
      end
      default: ;
    endcase
  end

  // Work RAM: the clearing pass owns the write port until it ends. A CPU write
  // lands at its accept edge, so a read accepted in the next cycle sees it.
  assign ram_we    = clearing || ram_item_write;
  assign ram_waddr = clearing ? clear_addr : ram_index;
  assign ram_wdata = clearing ? 8'd0 : write_data;

  bmsirq_ram #(
    .WIDTH (8),
    .DEPTH (WORK_RAM_DEPTH)
  ) u_work_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (ram_index),
    .rdata (ram_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_rom_banks <= 8'd2;
      chr_is_ram    <= 1'b0;
      quad_screen   <= 1'b0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        bmsirq_pkg::CFG_PRG_ROM_BANKS: prg_rom_banks <= cfg_data;
        bmsirq_pkg::CFG_CHR_IS_RAM:    chr_is_ram    <= cfg_data[0];
        bmsirq_pkg::CFG_QUAD_SCREEN:   quad_screen   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Mapper state and the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select       <= '0;
      bank_regs         <= '0;
      mirror_horizontal <= 1'b0;
      reload_period     <= '0;
      line_counter      <= '0;
      irq_enable        <= 1'b0;
      irq_pending       <= 1'b0;
      last_a12_cycle    <= '0;
      clearing          <= 1'b1;
      clear_addr        <= '0;
    end else begin
      bank_select       <= bank_select_next;
      bank_regs         <= bank_regs_next;
      mirror_horizontal <= mirror_horizontal_next;
      reload_period     <= reload_period_next;
      line_counter      <= line_counter_next;
      irq_enable        <= irq_enable_next;
      irq_pending       <= irq_pending_next;
      last_a12_cycle    <= last_a12_cycle_next;
      if (clearing) begin
        clear_addr <= clear_addr + 1'b1;
        if (clear_addr == RAM_AW'(WORK_RAM_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_accept || (s1_valid && !s1_advance);
      out_valid <= s1_advance || (out_valid && out_stall);
    end
  end

  // Stage one payload. Mirroring and the IRQ level are taken after the step.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind      <= step_kind;
      s1_address   <= step_address;
      s1_we        <= step_we;
      s1_mirroring <= quad_screen ? bmsirq_pkg::MIRROR_QUAD_SCREEN
                                  : {1'b0, mirror_horizontal_next};
      s1_irq       <= irq_pending_next;
    end
  end

  // Output register. The RAM byte is only reported for work RAM reads.
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_kind         <= s1_kind;
      ram_data         <= (s1_kind == bmsirq_pkg::KIND_RAM) ? ram_rdata : 8'd0;
      mapped_address   <= s1_address;
      chr_write_enable <= s1_we;
      mirroring        <= s1_mirroring;
      irq_line         <= s1_irq;
    end
  end

  assign kind = out_kind;

endmodule

`default_nettype wire
